@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros; each expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define HQI_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define HQI_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ rtl/core/hqi_pkg.sv @@
// ----------------------------------------------------------------------------
// hqi_pkg
// Shared constants, micro-op encoding and step program of the top integrator.
// ----------------------------------------------------------------------------
package hqi_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 24;
    localparam int IO_W            = 32;
    localparam int CFG_IDX_W       = 3;
    localparam int PC_W            = 6;
    localparam int PROG_LEN        = 47;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TORQUE_SCALE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GYRO_X       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GYRO_Y       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GYRO_Z       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INV_I_X      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_INV_I_Y      = 3'd6;

    localparam logic [30:0] RST_TIME_STEP    = 31'd1678;
    localparam logic [30:0] RST_TORQUE_SCALE = 31'd164416717;
    localparam logic [31:0] RST_GYRO_X       = 32'sd8388608;
    localparam logic [31:0] RST_GYRO_Y       = -32'sd8388608;
    localparam logic [31:0] RST_GYRO_Z       = 32'sd0;
    localparam logic [30:0] RST_INV_I_X      = 31'd83886080;
    localparam logic [30:0] RST_INV_I_Y      = 31'd83886080;

    // operand sources
    localparam logic [4:0] SRC_QW   = 5'd0;
    localparam logic [4:0] SRC_QX   = 5'd1;
    localparam logic [4:0] SRC_QY   = 5'd2;
    localparam logic [4:0] SRC_QZ   = 5'd3;
    localparam logic [4:0] SRC_WX   = 5'd4;
    localparam logic [4:0] SRC_WY   = 5'd5;
    localparam logic [4:0] SRC_WZ   = 5'd6;
    localparam logic [4:0] SRC_DT   = 5'd7;
    localparam logic [4:0] SRC_TS   = 5'd8;
    localparam logic [4:0] SRC_GX   = 5'd9;
    localparam logic [4:0] SRC_GY   = 5'd10;
    localparam logic [4:0] SRC_GZ   = 5'd11;
    localparam logic [4:0] SRC_IX   = 5'd12;
    localparam logic [4:0] SRC_IY   = 5'd13;
    localparam logic [4:0] SRC_HALF = 5'd14;
    localparam logic [4:0] SRC_ACC  = 5'd15;
    localparam logic [4:0] SRC_T1   = 5'd16;
    localparam logic [4:0] SRC_T2   = 5'd17;

    // operation kinds
    localparam logic [2:0] K_MUL  = 3'd0;  // acc = a*b
    localparam logic [2:0] K_MADD = 3'd1;  // acc = acc + a*b
    localparam logic [2:0] K_MSUB = 3'd2;  // acc = acc - a*b
    localparam logic [2:0] K_MNEG = 3'd3;  // acc = 0 - a*b
    localparam logic [2:0] K_DBL  = 3'd4;  // acc = acc + acc
    localparam logic [2:0] K_NEG  = 3'd5;  // acc = 0 - acc
    localparam logic [2:0] K_ADDA = 3'd6;  // acc = a + acc

    // result destinations
    localparam logic [3:0] D_NONE = 4'd0;
    localparam logic [3:0] D_T1   = 4'd1;
    localparam logic [3:0] D_T2   = 4'd2;
    localparam logic [3:0] D_QW   = 4'd3;
    localparam logic [3:0] D_QX   = 4'd4;
    localparam logic [3:0] D_QY   = 4'd5;
    localparam logic [3:0] D_QZ   = 4'd6;
    localparam logic [3:0] D_WX   = 4'd7;
    localparam logic [3:0] D_WY   = 4'd8;
    localparam logic [3:0] D_WZ   = 4'd9;

    typedef struct packed {
        logic [4:0] src_a;
        logic [4:0] src_b;
        logic [2:0] kind;
        logic [3:0] dest;
    } op_t;

    typedef struct packed {
        logic load;
        logic start;
        logic exec;
        logic commit;
        op_t  op;
    } cmd_t;

    function automatic op_t prog_op(input logic [PC_W-1:0] pc);
        op_t op;
        op = '{SRC_ACC, SRC_ACC, K_DBL, D_NONE};
        case (pc)
            // x torque
            6'd0:  op = '{SRC_QY,  SRC_QZ,   K_MUL,  D_NONE};
            6'd1:  op = '{SRC_QW,  SRC_QX,   K_MADD, D_NONE};
            6'd2:  op = '{SRC_ACC, SRC_ACC,  K_DBL,  D_NONE};
            6'd3:  op = '{SRC_ACC, SRC_TS,   K_MUL,  D_T1};
            // y torque
            6'd4:  op = '{SRC_QZ,  SRC_QX,   K_MUL,  D_NONE};
            6'd5:  op = '{SRC_QW,  SRC_QY,   K_MSUB, D_NONE};
            6'd6:  op = '{SRC_ACC, SRC_ACC,  K_DBL,  D_NONE};
            6'd7:  op = '{SRC_ACC, SRC_ACC,  K_NEG,  D_NONE};
            6'd8:  op = '{SRC_ACC, SRC_TS,   K_MUL,  D_T2};
            // quaternion w
            6'd9:  op = '{SRC_QX,  SRC_WX,   K_MNEG, D_NONE};
            6'd10: op = '{SRC_QY,  SRC_WY,   K_MSUB, D_NONE};
            6'd11: op = '{SRC_QZ,  SRC_WZ,   K_MSUB, D_NONE};
            6'd12: op = '{SRC_ACC, SRC_HALF, K_MUL,  D_NONE};
            6'd13: op = '{SRC_DT,  SRC_ACC,  K_MUL,  D_NONE};
            6'd14: op = '{SRC_QW,  SRC_ACC,  K_ADDA, D_QW};
            // quaternion x
            6'd15: op = '{SRC_QW,  SRC_WX,   K_MUL,  D_NONE};
            6'd16: op = '{SRC_QZ,  SRC_WY,   K_MSUB, D_NONE};
            6'd17: op = '{SRC_QY,  SRC_WZ,   K_MADD, D_NONE};
            6'd18: op = '{SRC_ACC, SRC_HALF, K_MUL,  D_NONE};
            6'd19: op = '{SRC_DT,  SRC_ACC,  K_MUL,  D_NONE};
            6'd20: op = '{SRC_QX,  SRC_ACC,  K_ADDA, D_QX};
            // quaternion y
            6'd21: op = '{SRC_QZ,  SRC_WX,   K_MUL,  D_NONE};
            6'd22: op = '{SRC_QW,  SRC_WY,   K_MADD, D_NONE};
            6'd23: op = '{SRC_QX,  SRC_WZ,   K_MSUB, D_NONE};
            6'd24: op = '{SRC_ACC, SRC_HALF, K_MUL,  D_NONE};
            6'd25: op = '{SRC_DT,  SRC_ACC,  K_MUL,  D_NONE};
            6'd26: op = '{SRC_QY,  SRC_ACC,  K_ADDA, D_QY};
            // quaternion z
            6'd27: op = '{SRC_QY,  SRC_WX,   K_MNEG, D_NONE};
            6'd28: op = '{SRC_QX,  SRC_WY,   K_MADD, D_NONE};
            6'd29: op = '{SRC_QW,  SRC_WZ,   K_MADD, D_NONE};
            6'd30: op = '{SRC_ACC, SRC_HALF, K_MUL,  D_NONE};
            6'd31: op = '{SRC_DT,  SRC_ACC,  K_MUL,  D_NONE};
            6'd32: op = '{SRC_QZ,  SRC_ACC,  K_ADDA, D_QZ};
            // rate x
            6'd33: op = '{SRC_GX,  SRC_WY,   K_MUL,  D_NONE};
            6'd34: op = '{SRC_ACC, SRC_WZ,   K_MUL,  D_NONE};
            6'd35: op = '{SRC_T1,  SRC_IX,   K_MADD, D_NONE};
            6'd36: op = '{SRC_DT,  SRC_ACC,  K_MUL,  D_NONE};
            6'd37: op = '{SRC_WX,  SRC_ACC,  K_ADDA, D_WX};
            // rate y
            6'd38: op = '{SRC_GY,  SRC_WZ,   K_MUL,  D_NONE};
            6'd39: op = '{SRC_ACC, SRC_WX,   K_MUL,  D_NONE};
            6'd40: op = '{SRC_T2,  SRC_IY,   K_MADD, D_NONE};
            6'd41: op = '{SRC_DT,  SRC_ACC,  K_MUL,  D_NONE};
            6'd42: op = '{SRC_WY,  SRC_ACC,  K_ADDA, D_WY};
            // rate z
            6'd43: op = '{SRC_GZ,  SRC_WX,   K_MUL,  D_NONE};
            6'd44: op = '{SRC_ACC, SRC_WY,   K_MUL,  D_NONE};
            6'd45: op = '{SRC_DT,  SRC_ACC,  K_MUL,  D_NONE};
            6'd46: op = '{SRC_WZ,  SRC_ACC,  K_ADDA, D_WZ};
            default: op = '{SRC_ACC, SRC_ACC, K_DBL, D_NONE};
        endcase
        return op;
    endfunction

endpackage

@@ rtl/core/hqi_ctrl.sv @@
// ----------------------------------------------------------------------------
// hqi_ctrl
// Sequencer: accepts requests, steps the micro-op program, hands off results.
// ----------------------------------------------------------------------------
module hqi_ctrl
    import hqi_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  logic req_type,
    output logic out_valid,
    input  logic out_ready,
    output cmd_t cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]      state_reg, state_next;
    logic [PC_W-1:0] pc_reg, pc_next;
    logic            out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        pc_next        = pc_reg;
        cmd            = '0;
        cmd.op         = prog_op(pc_reg);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (req_type)
                    begin
                        cmd.start  = 1'b1;
                        pc_next    = '0;
                        state_next = ST_RUN;
                    end
                    else
                    begin
                        cmd.load   = 1'b1;
                        state_next = ST_DONE;
                    end
                end
            end
            ST_RUN:
            begin
                cmd.exec = 1'b1;
                pc_next  = pc_reg + 1'b1;
                if (pc_reg == PC_W'(PROG_LEN - 1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // hold until the output slot is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        out_valid_next = cmd.commit ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pc_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

@@ rtl/core/hqi_dp.sv @@
// ----------------------------------------------------------------------------
// hqi_dp
// Datapath: config registers, state, one rounding multiplier and a
// saturating accumulator.
// ----------------------------------------------------------------------------
module hqi_dp
    import hqi_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cmd_t                 cmd,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [IO_W-1:0]      cfg_data,
    input  logic [IO_W-1:0]      load_qw,
    input  logic [IO_W-1:0]      load_qx,
    input  logic [IO_W-1:0]      load_qy,
    input  logic [IO_W-1:0]      load_qz,
    input  logic [IO_W-1:0]      load_rate_x,
    input  logic [IO_W-1:0]      load_rate_y,
    input  logic [IO_W-1:0]      load_rate_z,
    output logic [IO_W-1:0]      out_qw,
    output logic [IO_W-1:0]      out_qx,
    output logic [IO_W-1:0]      out_qy,
    output logic [IO_W-1:0]      out_qz,
    output logic [IO_W-1:0]      out_rate_x,
    output logic [IO_W-1:0]      out_rate_y,
    output logic [IO_W-1:0]      out_rate_z,
    output logic                 saturated
);

    localparam int W    = VALUE_WIDTH;
    localparam int OPW0 = (W > IO_W) ? W : IO_W;
    localparam int OPW  = (FRAC_BITS + 1 > OPW0) ? FRAC_BITS + 1 : OPW0;
    localparam int PW   = 2 * OPW;

    localparam logic signed [OPW-1:0] MAXV_O =
        {{(OPW - W + 1){1'b0}}, {(W - 1){1'b1}}};
    localparam logic signed [OPW-1:0] MINV_O = ~MAXV_O;
    localparam logic signed [W-1:0]   MAXV   = MAXV_O[W-1:0];
    localparam logic signed [W-1:0]   MINV   = ~MAXV;
    localparam logic [PW:0] MAXV_X = {{(PW + 2 - W){1'b0}}, {(W - 1){1'b1}}};
    localparam logic [PW:0] RND    = (PW + 1)'(1) << (FRAC_BITS - 1);
    localparam logic signed [OPW-1:0] HALF_O = OPW'(1) << (FRAC_BITS - 1);
    localparam logic signed [OPW-1:0] ONE_O  = OPW'(1) << FRAC_BITS;
    localparam logic signed [W-1:0]   ONE_V  =
        (ONE_O > MAXV_O) ? MAXV : ONE_O[W-1:0];

    // config
    logic [30:0]        dt_reg, ts_reg, ix_reg, iy_reg;
    logic signed [31:0] gx_reg, gy_reg, gz_reg;

    // architectural state, next state under construction, outputs
    logic signed [W-1:0] qw_reg, qx_reg, qy_reg, qz_reg, wx_reg, wy_reg, wz_reg;
    logic signed [W-1:0] nqw_reg, nqx_reg, nqy_reg, nqz_reg;
    logic signed [W-1:0] nwx_reg, nwy_reg, nwz_reg;
    logic signed [W-1:0] oqw_reg, oqx_reg, oqy_reg, oqz_reg;
    logic signed [W-1:0] owx_reg, owy_reg, owz_reg;
    logic                osat_reg;
    logic signed [W-1:0] acc_reg, t1_reg, t2_reg;
    logic                flag_reg;

    logic signed [OPW-1:0] opa, opb;
    logic signed [PW-1:0]  prod;
    logic                  pneg;
    logic [PW-1:0]         pmag;
    logic [PW:0]           rq;
    logic [PW:0]           plim;
    logic                  pclip;
    logic signed [W-1:0]   pres;
    logic [W:0]            sres;
    logic signed [W-1:0]   res;
    logic                  rclip;
    logic [W:0]            ld_w, ld_x, ld_y, ld_z, ld_rx, ld_ry, ld_rz;

    function automatic logic [W:0] sat_add(input logic signed [W-1:0] a,
                                           input logic signed [W-1:0] b);
        logic signed [W:0] s;
        s = {a[W-1], a} + {b[W-1], b};
        if (s[W] != s[W-1])
        begin
            return {1'b1, s[W] ? MINV : MAXV};
        end
        return {1'b0, s[W-1:0]};
    endfunction

    function automatic logic [W:0] sat_sub(input logic signed [W-1:0] a,
                                           input logic signed [W-1:0] b);
        logic signed [W:0] s;
        s = {a[W-1], a} - {b[W-1], b};
        if (s[W] != s[W-1])
        begin
            return {1'b1, s[W] ? MINV : MAXV};
        end
        return {1'b0, s[W-1:0]};
    endfunction

    function automatic logic [W:0] clamp_in(input logic [IO_W-1:0] v);
        logic signed [OPW-1:0] x;
        x = OPW'($signed(v));
        if (x > MAXV_O)
        begin
            return {1'b1, MAXV};
        end
        if (x < MINV_O)
        begin
            return {1'b1, MINV};
        end
        return {1'b0, x[W-1:0]};
    endfunction

    function automatic logic signed [OPW-1:0] pick(
        input logic [4:0] src,
        input logic signed [W-1:0] qw, qx, qy, qz, wx, wy, wz, acc, t1, t2,
        input logic [30:0] dt, ts, ix, iy,
        input logic signed [31:0] gx, gy, gz);
        logic signed [OPW-1:0] v;
        v = '0;
        case (src)
            SRC_QW:   v = OPW'(qw);
            SRC_QX:   v = OPW'(qx);
            SRC_QY:   v = OPW'(qy);
            SRC_QZ:   v = OPW'(qz);
            SRC_WX:   v = OPW'(wx);
            SRC_WY:   v = OPW'(wy);
            SRC_WZ:   v = OPW'(wz);
            SRC_DT:   v = OPW'(dt);
            SRC_TS:   v = OPW'(ts);
            SRC_GX:   v = OPW'(gx);
            SRC_GY:   v = OPW'(gy);
            SRC_GZ:   v = OPW'(gz);
            SRC_IX:   v = OPW'(ix);
            SRC_IY:   v = OPW'(iy);
            SRC_HALF: v = HALF_O;
            SRC_ACC:  v = OPW'(acc);
            SRC_T1:   v = OPW'(t1);
            SRC_T2:   v = OPW'(t2);
            default:  v = '0;
        endcase
        return v;
    endfunction

    always_comb
    begin
        opa = pick(cmd.op.src_a, qw_reg, qx_reg, qy_reg, qz_reg, wx_reg, wy_reg,
                   wz_reg, acc_reg, t1_reg, t2_reg, dt_reg, ts_reg, ix_reg,
                   iy_reg, gx_reg, gy_reg, gz_reg);
        opb = pick(cmd.op.src_b, qw_reg, qx_reg, qy_reg, qz_reg, wx_reg, wy_reg,
                   wz_reg, acc_reg, t1_reg, t2_reg, dt_reg, ts_reg, ix_reg,
                   iy_reg, gx_reg, gy_reg, gz_reg);

        // exact product, round half away from zero on the magnitude
        prod  = opa * opb;
        pneg  = prod[PW-1];
        pmag  = pneg ? PW'(-prod) : PW'(prod);
        rq    = ({1'b0, pmag} + RND) >> FRAC_BITS;
        plim  = pneg ? MAXV_X + 1'b1 : MAXV_X;
        pclip = (rq > plim);
        if (pclip)
        begin
            pres = pneg ? MINV : MAXV;
        end
        else
        begin
            pres = pneg ? -W'(rq) : W'(rq);
        end

        sres = {1'b0, pres};
        case (cmd.op.kind)
            K_MUL:   sres = {pclip, pres};
            K_MADD:  sres = sat_add(acc_reg, pres);
            K_MSUB:  sres = sat_sub(acc_reg, pres);
            K_MNEG:  sres = sat_sub('0, pres);
            K_DBL:   sres = sat_add(acc_reg, acc_reg);
            K_NEG:   sres = sat_sub('0, acc_reg);
            K_ADDA:  sres = sat_add(opa[W-1:0], acc_reg);
            default: sres = {1'b0, acc_reg};
        endcase
        res   = sres[W-1:0];
        rclip = sres[W] | (pclip && (cmd.op.kind == K_MADD || cmd.op.kind == K_MSUB ||
                                      cmd.op.kind == K_MNEG));

        ld_w  = clamp_in(load_qw);
        ld_x  = clamp_in(load_qx);
        ld_y  = clamp_in(load_qy);
        ld_z  = clamp_in(load_qz);
        ld_rx = clamp_in(load_rate_x);
        ld_ry = clamp_in(load_rate_y);
        ld_rz = clamp_in(load_rate_z);
    end

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dt_reg <= RST_TIME_STEP;
            ts_reg <= RST_TORQUE_SCALE;
            gx_reg <= RST_GYRO_X;
            gy_reg <= RST_GYRO_Y;
            gz_reg <= RST_GYRO_Z;
            ix_reg <= RST_INV_I_X;
            iy_reg <= RST_INV_I_Y;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TIME_STEP:    dt_reg <= cfg_data[30:0];
                REG_TORQUE_SCALE: ts_reg <= cfg_data[30:0];
                REG_GYRO_X:       gx_reg <= cfg_data;
                REG_GYRO_Y:       gy_reg <= cfg_data;
                REG_GYRO_Z:       gz_reg <= cfg_data;
                REG_INV_I_X:      ix_reg <= cfg_data[30:0];
                REG_INV_I_Y:      iy_reg <= cfg_data[30:0];
                default:          ;
            endcase
        end
    end

    // architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qw_reg <= ONE_V;
            qx_reg <= '0;
            qy_reg <= '0;
            qz_reg <= '0;
            wx_reg <= '0;
            wy_reg <= '0;
            wz_reg <= '0;
        end
        else if (cmd.commit)
        begin
            qw_reg <= nqw_reg;
            qx_reg <= nqx_reg;
            qy_reg <= nqy_reg;
            qz_reg <= nqz_reg;
            wx_reg <= nwx_reg;
            wy_reg <= nwy_reg;
            wz_reg <= nwz_reg;
        end
    end

    // working registers and output hold
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            nqw_reg  <= ld_w[W-1:0];
            nqx_reg  <= ld_x[W-1:0];
            nqy_reg  <= ld_y[W-1:0];
            nqz_reg  <= ld_z[W-1:0];
            nwx_reg  <= ld_rx[W-1:0];
            nwy_reg  <= ld_ry[W-1:0];
            nwz_reg  <= ld_rz[W-1:0];
            flag_reg <= ld_w[W] | ld_x[W] | ld_y[W] | ld_z[W] |
                        ld_rx[W] | ld_ry[W] | ld_rz[W];
        end
        if (cmd.start)
        begin
            flag_reg <= 1'b0;
        end
        if (cmd.exec)
        begin
            acc_reg  <= res;
            flag_reg <= flag_reg | rclip;
            case (cmd.op.dest)
                D_T1:    t1_reg  <= res;
                D_T2:    t2_reg  <= res;
                D_QW:    nqw_reg <= res;
                D_QX:    nqx_reg <= res;
                D_QY:    nqy_reg <= res;
                D_QZ:    nqz_reg <= res;
                D_WX:    nwx_reg <= res;
                D_WY:    nwy_reg <= res;
                D_WZ:    nwz_reg <= res;
                default: ;
            endcase
        end
        if (cmd.commit)
        begin
            oqw_reg  <= nqw_reg;
            oqx_reg  <= nqx_reg;
            oqy_reg  <= nqy_reg;
            oqz_reg  <= nqz_reg;
            owx_reg  <= nwx_reg;
            owy_reg  <= nwy_reg;
            owz_reg  <= nwz_reg;
            osat_reg <= flag_reg;
        end
    end

    assign out_qw     = IO_W'(OPW'(oqw_reg));
    assign out_qx     = IO_W'(OPW'(oqx_reg));
    assign out_qy     = IO_W'(OPW'(oqy_reg));
    assign out_qz     = IO_W'(OPW'(oqz_reg));
    assign out_rate_x = IO_W'(OPW'(owx_reg));
    assign out_rate_y = IO_W'(OPW'(owy_reg));
    assign out_rate_z = IO_W'(OPW'(owz_reg));
    assign saturated  = osat_reg;

endmodule

@@ rtl/core/heavy_top_quaternion_integrator.sv @@
// ----------------------------------------------------------------------------
// heavy_top_quaternion_integrator
// Forward-Euler step of a heavy symmetric top in saturating fixed point.
//
//   channel   direction   handshake             payload
//   in        request     in_valid / in_ready   req_type, load_*
//   out       result      out_valid / out_ready out_q*, out_rate_*, saturated
//   cfg       write       cfg_valid / cfg_ready cfg_index, cfg_data
//
// A load request goes via the done state to its result; a step request
// runs the 47 micro-ops, which share the single rounding multiplier.
// One request is in flight at a time; in_ready is high only when idle.
// A finished result waits in the output register; a stalled output holds
// the next result at handoff. Async reset restores the identity attitude.
// ----------------------------------------------------------------------------
module heavy_top_quaternion_integrator
    import hqi_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 req_type,
    input  logic [IO_W-1:0]      load_qw,
    input  logic [IO_W-1:0]      load_qx,
    input  logic [IO_W-1:0]      load_qy,
    input  logic [IO_W-1:0]      load_qz,
    input  logic [IO_W-1:0]      load_rate_x,
    input  logic [IO_W-1:0]      load_rate_y,
    input  logic [IO_W-1:0]      load_rate_z,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [IO_W-1:0]      out_qw,
    output logic [IO_W-1:0]      out_qx,
    output logic [IO_W-1:0]      out_qy,
    output logic [IO_W-1:0]      out_qz,
    output logic [IO_W-1:0]      out_rate_x,
    output logic [IO_W-1:0]      out_rate_y,
    output logic [IO_W-1:0]      out_rate_z,
    output logic                 saturated,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [IO_W-1:0]      cfg_data
);

    cmd_t cmd;

    assign cfg_ready = 1'b1;

    hqi_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .req_type  (req_type),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    hqi_dp #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .cfg_we      (cfg_valid & cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .load_qw     (load_qw),
        .load_qx     (load_qx),
        .load_qy     (load_qy),
        .load_qz     (load_qz),
        .load_rate_x (load_rate_x),
        .load_rate_y (load_rate_y),
        .load_rate_z (load_rate_z),
        .out_qw      (out_qw),
        .out_qx      (out_qx),
        .out_qy      (out_qy),
        .out_qz      (out_qz),
        .out_rate_x  (out_rate_x),
        .out_rate_y  (out_rate_y),
        .out_rate_z  (out_rate_z),
        .saturated   (saturated)
    );

endmodule

@@ rtl/core/hqi_checker.sv @@
// ----------------------------------------------------------------------------
// hqi_props
// Port-level checks on request flow and result handoff of the integrator.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hqi_props
    import hqi_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input logic                 req_type,
    input logic                 out_valid,
    input logic                 out_ready,
    input logic [IO_W-1:0]      out_qw,
    input logic [IO_W-1:0]      out_rate_z,
    input logic                 saturated
);

    // a stalled result stays put
    `HQI_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid)
    `HQI_ASSERT_NXT(a_out_stable, out_valid && !out_ready,
                    $stable(out_qw) && $stable(out_rate_z) && $stable(saturated))
    // one request at a time
    `HQI_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
    // a new result goes out as the sequencer frees up
    `HQI_ASSERT_IMP(a_result_frees, $rose(out_valid), in_ready)
    // a load into an empty output slot goes through the done state without a stall
    `HQI_ASSERT_IMP(a_load_latency, in_valid && in_ready && !req_type && !out_valid,
                    ##2 out_valid)

endmodule

bind heavy_top_quaternion_integrator hqi_props u_hqi_props (.*);
